### rtl/cstf_pkg.sv
// shared types, register codes and helpers for the character stuffing framer
package cstf_pkg;

  typedef struct packed {
    logic [31:0] start_delim;
    logic [2:0]  start_len;
    logic [31:0] end_delim;
    logic [2:0]  end_len;
    logic [31:0] stuff_seq;
    logic [2:0]  stuff_len;
  } cfg_t;

  typedef enum logic [2:0] {
    IDX_START_DELIM = 3'd0,
    IDX_START_LEN   = 3'd1,
    IDX_END_DELIM   = 3'd2,
    IDX_END_LEN     = 3'd3,
    IDX_STUFF_SEQ   = 3'd4,
    IDX_STUFF_LEN   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic need_start;
    logic last;
    logic full;
  } job_ctl_t;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_POS   = 3'b010,
    PH_END   = 3'b100
  } phase_t;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ESC   = 2'd2;
  localparam logic [1:0] KIND_BYTE  = 2'd3;

  // "esc", first character in the low byte
  localparam logic [23:0] ESC_LIT = 24'h637365;

  localparam logic [31:0] DEF_DELIM = 32'd126;
  localparam logic [31:0] DEF_STUFF = 32'd27;
  localparam logic [2:0]  DEF_LEN   = 3'd1;

  function automatic logic [2:0] clamp4(input logic [2:0] len);
    return len[2] ? 3'd4 : len;
  endfunction

endpackage

### rtl/cstf_cfg_regs.sv
// configuration register file for the framer
module cstf_cfg_regs import cstf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delim <= DEF_DELIM;
      cfg.start_len   <= DEF_LEN;
      cfg.end_delim   <= DEF_DELIM;
      cfg.end_len     <= DEF_LEN;
      cfg.stuff_seq   <= DEF_STUFF;
      cfg.stuff_len   <= DEF_LEN;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        IDX_START_DELIM: cfg.start_delim <= wr_data;
        IDX_START_LEN:   cfg.start_len   <= wr_data[2:0];
        IDX_END_DELIM:   cfg.end_delim   <= wr_data;
        IDX_END_LEN:     cfg.end_len     <= wr_data[2:0];
        IDX_STUFF_SEQ:   cfg.stuff_seq   <= wr_data;
        IDX_STUFF_LEN:   cfg.stuff_len   <= wr_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/cstf_window.sv
// look-ahead window, frame state and per-position delimiter matching
module cstf_window import cstf_pkg::*; #(
  parameter int MAX_DELIM = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cfg_t                               cfg,
  input  logic                               accept,
  input  logic [7:0]                         data_byte,
  input  logic                               frame_end,
  output job_ctl_t                           ctl,
  output logic [MAX_DELIM-1:0][7:0]          win,
  output logic [MAX_DELIM-1:0][2:0]          flags,
  output logic [$clog2(MAX_DELIM+1)-1:0]     npos
);

  localparam int PW = $clog2(MAX_DELIM);
  localparam int CW = $clog2(MAX_DELIM + 1);

  logic [MAX_DELIM-2:0][7:0] la;
  logic [PW-1:0]             count;
  logic                      in_frame;
  logic [CW-1:0]             n;
  logic                      full;

  function automatic int match_len(input logic [2:0] len);
    int l;
    l = int'(clamp4(len));
    return (l > MAX_DELIM) ? MAX_DELIM : l;
  endfunction

  function automatic logic seq_match(input logic [MAX_DELIM-1:0][7:0] w, input int nn,
                                     input int p, input logic [31:0] seq, input int l);
    logic ok;
    int   idx;
    ok = (p + l <= nn);
    for (int i = 0; i < 4; i++) begin
      idx = p + i;
      if (i < l && idx < MAX_DELIM) begin
        if (w[idx[PW-1:0]] != seq[8*i +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  always_comb begin
    n    = CW'(count) + CW'(1);
    full = (n == CW'(MAX_DELIM));
    for (int i = 0; i < MAX_DELIM - 1; i++) begin
      if (PW'(i) < count) win[i] = la[i];
      else if (PW'(i) == count) win[i] = data_byte;
      else win[i] = 8'h00;
    end
    win[MAX_DELIM-1] = (count == PW'(MAX_DELIM - 1)) ? data_byte : 8'h00;
    for (int p = 0; p < MAX_DELIM; p++) begin
      flags[p][KIND_START] = seq_match(win, int'(n), p, cfg.start_delim,
                                       match_len(cfg.start_len));
      flags[p][KIND_END]   = seq_match(win, int'(n), p, cfg.end_delim,
                                       match_len(cfg.end_len));
      flags[p][KIND_ESC]   = seq_match(win, int'(n), p, {8'h00, ESC_LIT}, 3);
    end
    ctl.need_start = !in_frame;
    ctl.last       = frame_end;
    ctl.full       = full;
    npos = frame_end ? n : (full ? CW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      in_frame <= 1'b0;
    end else if (accept) begin
      in_frame <= !frame_end;
      if (frame_end) count <= '0;
      else if (full) count <= PW'(MAX_DELIM - 1);
      else count <= count + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !frame_end) begin
      for (int i = 0; i < MAX_DELIM - 1; i++) begin
        if (full) la[i] <= win[i+1];
        else if (count == PW'(i)) la[i] <= data_byte;
      end
    end
  end

endmodule

### rtl/cstf_emitter.sv
// job register and byte sequencer with output register
module cstf_emitter import cstf_pkg::*; #(
  parameter int MAX_DELIM = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic                           accept,
  input  job_ctl_t                       ctl,
  input  logic [MAX_DELIM-1:0][7:0]      win,
  input  logic [MAX_DELIM-1:0][2:0]      flags,
  input  logic [$clog2(MAX_DELIM+1)-1:0] npos,
  output logic                           ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           run_last,
  output logic                           frame_done
);

  localparam int PW = $clog2(MAX_DELIM);
  localparam int CW = $clog2(MAX_DELIM + 1);

  logic                      jv;
  logic                      j_last;
  logic [MAX_DELIM-1:0][7:0] j_win;
  logic [MAX_DELIM-1:0][2:0] j_flags;
  logic [CW-1:0]             j_npos;
  phase_t                    ph;
  logic [PW-1:0]             p;
  logic [1:0]                kind;
  logic [1:0]                j;

  phase_t        ph_next;
  logic [PW-1:0] p_next;
  logic [1:0]    kind_next;
  logic [1:0]    j_next;
  logic          done;
  logic          emit;
  logic          has_out;
  logic          end_need;
  logic          ul_nz;
  logic [2:0]    sl;
  logic [2:0]    ul;
  logic [2:0]    el;
  logic [2:0]    seg_len;
  logic [7:0]    cur_byte;
  logic [PW:0]   p_inc;
  logic [3:0]    am_cur;
  logic [3:0]    am_inc;
  logic [3:0]    am_first;
  logic [3:0]    am_load;

  function automatic logic [3:0] active(input logic [2:0] f, input logic nz);
    return {1'b1, f & {3{nz}}};
  endfunction

  function automatic logic [1:0] first_kind(input logic [3:0] am, input logic [1:0] k);
    logic [1:0] r;
    r = KIND_BYTE;
    for (int i = 3; i >= 0; i--) begin
      if (am[i] && 2'(i) >= k) r = 2'(i);
    end
    return r;
  endfunction

  always_comb begin
    sl       = clamp4(cfg.start_len);
    ul       = clamp4(cfg.stuff_len);
    el       = clamp4(cfg.end_len);
    ul_nz    = (ul != 3'd0);
    emit     = jv && (!out_valid || out_ready);
    end_need = j_last && (el != 3'd0);
    has_out  = (ctl.need_start && sl != 3'd0) || ctl.last || ctl.full;
    p_inc    = {1'b0, p} + (PW+1)'(1);
    am_cur   = active(j_flags[p], ul_nz);
    am_first = active(j_flags[0], ul_nz);
    am_load  = active(flags[0], ul_nz);
    if (int'(p_inc) < MAX_DELIM) am_inc = active(j_flags[p_inc[PW-1:0]], ul_nz);
    else am_inc = 4'b1000;

    case (ph)
      PH_START: begin
        seg_len  = sl;
        cur_byte = cfg.start_delim[{j, 3'b000} +: 8];
      end
      PH_POS: begin
        seg_len  = (kind == KIND_BYTE) ? 3'd1 : ul;
        cur_byte = (kind == KIND_BYTE) ? j_win[p] : cfg.stuff_seq[{j, 3'b000} +: 8];
      end
      PH_END: begin
        seg_len  = el;
        cur_byte = cfg.end_delim[{j, 3'b000} +: 8];
      end
      default: begin
        seg_len  = 3'd1;
        cur_byte = 8'h00;
      end
    endcase

    ph_next   = ph;
    p_next    = p;
    kind_next = kind;
    j_next    = j;
    done      = 1'b0;
    if ({1'b0, j} + 3'd1 < seg_len) begin
      j_next = j + 2'd1;
    end else begin
      j_next = 2'd0;
      case (ph)
        PH_START: begin
          if (j_npos != '0) begin
            ph_next   = PH_POS;
            p_next    = '0;
            kind_next = first_kind(am_first, KIND_START);
          end else if (end_need) begin
            ph_next = PH_END;
          end else begin
            done = 1'b1;
          end
        end
        PH_POS: begin
          if (kind != KIND_BYTE) begin
            kind_next = first_kind(am_cur, kind + 2'd1);
          end else if (int'(p_inc) < int'(j_npos)) begin
            p_next    = p_inc[PW-1:0];
            kind_next = first_kind(am_inc, KIND_START);
          end else if (end_need) begin
            ph_next = PH_END;
          end else begin
            done = 1'b1;
          end
        end
        PH_END:  done = 1'b1;
        default: done = 1'b1;
      endcase
    end

    ready = !jv || (emit && done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jv        <= 1'b0;
      out_valid <= 1'b0;
      ph        <= PH_START;
      p         <= '0;
      kind      <= KIND_START;
      j         <= 2'd0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (accept && has_out) begin
        jv <= 1'b1;
        p  <= '0;
        j  <= 2'd0;
        if (ctl.need_start && sl != 3'd0) begin
          ph   <= PH_START;
          kind <= KIND_START;
        end else begin
          ph   <= PH_POS;
          kind <= first_kind(am_load, KIND_START);
        end
      end else if (emit) begin
        if (done) jv <= 1'b0;
        ph   <= ph_next;
        p    <= p_next;
        kind <= kind_next;
        j    <= j_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_out) begin
      j_last  <= ctl.last;
      j_win   <= win;
      j_flags <= flags;
      j_npos  <= npos;
    end
    if (emit) begin
      out_byte   <= cur_byte;
      run_last   <= done;
      frame_done <= done && j_last;
    end
  end

endmodule

### rtl/character_stuffing_framer_core.sv
// top level of the character stuffing framer
// an item that releases bytes passes the job register, then the output register, before
// its first byte shows; a payload byte waits for MAX_DELIM-1 later bytes or for the end
// of its frame. throughput: the sequencer sends one byte a cycle unless m_tready stalls
// it, so an item that causes more than one byte holds the input until its last byte is
// sent; items causing zero or one byte go at one a cycle when the output does not stall.
// reset (synchronous): window emptied, idle between frames, registers back to their defaults
module character_stuffing_framer_core import cstf_pkg::*; #(
  parameter int MAX_DELIM = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,   // run_last
  output logic [0:0]  m_tuser,   // frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t                           cfg;
  job_ctl_t                       ctl;
  logic [MAX_DELIM-1:0][7:0]      win;
  logic [MAX_DELIM-1:0][2:0]      flags;
  logic [$clog2(MAX_DELIM+1)-1:0] npos;
  logic                           accept;
  logic                           done_flag;

  assign cfg_ready  = 1'b1;
  assign accept     = s_tvalid && s_tready;
  assign m_tuser[0] = done_flag;

  cstf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cstf_window #(.MAX_DELIM(MAX_DELIM)) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (s_tdata),
    .frame_end (s_tlast),
    .ctl       (ctl),
    .win       (win),
    .flags     (flags),
    .npos      (npos)
  );

  cstf_emitter #(.MAX_DELIM(MAX_DELIM)) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .ctl        (ctl),
    .win        (win),
    .flags      (flags),
    .npos       (npos),
    .ready      (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .run_last   (m_tlast),
    .frame_done (done_flag)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("frame done flag on a byte that does not end its item");

  a_frame_end_emits: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |-> ##2 m_tvalid)
    else $error("frame end item produced no output");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("output stopped inside an item's byte run");

endmodule
